@@ design/modexp_pkg.sv @@
// Shared types and constants for the modular exponentiation core.
package modexp_pkg;

   // Width of the base, exponent, modulus and result words.
   localparam int OPERAND_BITS = 32;
   localparam int COUNT_BITS   = $clog2(OPERAND_BITS);

   typedef logic [OPERAND_BITS-1:0] operand_type;

   // Sequencer states of the exponentiation loop.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MULT,
      ST_SQUARE,
      ST_DONE
   } state_type;

   // Launch of one modular multiplication on the shared unit.
   typedef struct packed {
      logic        start;
      operand_type multiplicand;
      operand_type multiplier;
   } mm_req_type;

   // Completion of one modular multiplication.
   typedef struct packed {
      logic        done;
      operand_type product;
   } mm_rsp_type;

endpackage

@@ design/modexp_mulmod.sv @@
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
module modexp_mulmod (
   input  logic                    clock,
   input  logic                    reset,
   input  modexp_pkg::operand_type modulus,
   input  modexp_pkg::mm_req_type  mm_req,
   output modexp_pkg::mm_rsp_type  mm_rsp
);
   import modexp_pkg::*;

   // (a + b) mod n for a, b below n; the sum keeps its carry bit.
   function automatic operand_type add_mod(operand_type a, operand_type b, operand_type n);
      logic [OPERAND_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, n}) begin
         sum = sum - {1'b0, n};
      end
      return sum[OPERAND_BITS-1:0];
   endfunction

   operand_type           acc_ff, acc_in;
   operand_type           mcand_ff, mcand_in;
   operand_type           mplr_ff, mplr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  running_ff, running_in;
   logic                  done_ff, done_in;
   operand_type           doubled;

   always_comb begin
      acc_in     = acc_ff;
      mcand_in   = mcand_ff;
      mplr_in    = mplr_ff;
      count_in   = count_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      doubled    = add_mod(acc_ff, acc_ff, modulus);
      if (mm_req.start) begin
         acc_in     = '0;
         mcand_in   = mm_req.multiplicand;
         mplr_in    = mm_req.multiplier;
         count_in   = COUNT_BITS'(OPERAND_BITS - 1);
         running_in = 1'b1;
      end else if (running_ff) begin
         // Horner step: double, then add the multiplicand if the top bit is set.
         acc_in   = mplr_ff[OPERAND_BITS-1] ? add_mod(doubled, mcand_ff, modulus) : doubled;
         mplr_in  = {mplr_ff[OPERAND_BITS-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
      count_ff <= count_in;
   end

   assign mm_rsp.done    = done_ff;
   assign mm_rsp.product = acc_ff;

endmodule

@@ design/modular_exponentiation_core.sv @@
// Top level of the modular exponentiation core: sequencer and configuration register.
//
// Usage: write the modulus through the csr_ channel (csr_valid with csr_ready,
// which is always high) while the core is idle. The modulus resets to 1.
// Present a base and an exponent on req_base_value and req_exponent with start;
// the word is taken at a clock edge where start is high and busy is low. The core
// then raises busy and accepts nothing until its result has been delivered.
// The result word appears on rsp_power_result for exactly one cycle, marked by
// rsp_valid. The receiver cannot stall it, so it must take the word in that cycle.
// Sequence: one shared bit-serial modular multiplier does all the arithmetic, and
// each multiplication steps through the 32 multiplier bits before it completes.
// The base is first reduced mod n; then each exponent bit, lowest first, is
// checked. Every exponent bit below the highest set bit costs a squaring, after
// a multiplication into the result when the bit is set, and the highest set bit
// costs its multiplication, after which the result word is delivered. An exponent
// of zero or a modulus of zero skips the multiplier and goes straight to the result.
// A new item can be started the cycle after rsp_valid. Reset returns the
// sequencer to idle, drops any item in progress and restores the modulus to 1.
module modular_exponentiation_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  modexp_pkg::operand_type req_base_value,
   input  modexp_pkg::operand_type req_exponent,
   output logic                    rsp_valid,
   output modexp_pkg::operand_type rsp_power_result,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  modexp_pkg::operand_type csr_modulus
);
   import modexp_pkg::*;

   state_type   state_ff, state_in;
   operand_type modulus_ff;
   operand_type base_ff, base_in;
   operand_type exp_ff, exp_in;
   operand_type result_ff, result_in;
   operand_type one_mod;
   logic        accept;
   logic        more_bits;
   mm_req_type  mm_req;
   mm_rsp_type  mm_rsp;

   // The configuration channel never pushes back.
   assign csr_ready = 1'b1;

   assign accept    = start && (state_ff == ST_IDLE);
   // 1 mod n: zero only for a modulus of one.
   assign one_mod   = (modulus_ff == operand_type'(1)) ? '0 : operand_type'(1);
   // True while exponent bits above the current one remain set.
   assign more_bits = (exp_ff[OPERAND_BITS-1:1] != '0);

   modexp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .mm_req  (mm_req),
      .mm_rsp  (mm_rsp)
   );

   // Next state of the square-and-multiply sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_exponent == '0) || (modulus_ff == '0)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_rsp.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = exp_ff[0] ? ST_MULT : ST_SQUARE;
         end
         ST_MULT: begin
            if (mm_rsp.done) begin
               state_in = more_bits ? ST_SQUARE : ST_DONE;
            end
         end
         ST_SQUARE: begin
            if (mm_rsp.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Launches of the shared multiplier and updates of the working words.
   always_comb begin
      mm_req    = '0;
      base_in   = base_ff;
      exp_in    = exp_ff;
      result_in = result_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               exp_in = req_exponent;
               if (req_exponent == '0) begin
                  // A zero exponent gives 1, left unreduced.
                  result_in = operand_type'(1);
               end else if (modulus_ff == '0) begin
                  result_in = '0;
               end else begin
                  result_in = one_mod;
                  // Reduce the base: (1 mod n) times base, taken mod n.
                  mm_req.start        = 1'b1;
                  mm_req.multiplicand = one_mod;
                  mm_req.multiplier   = req_base_value;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_rsp.done) begin
               base_in = mm_rsp.product;
            end
         end
         ST_CHECK: begin
            // Multiply the result in when the bit is set, else square right away.
            mm_req.start        = 1'b1;
            mm_req.multiplicand = exp_ff[0] ? result_ff : base_ff;
            mm_req.multiplier   = base_ff;
         end
         ST_MULT: begin
            if (mm_rsp.done) begin
               result_in = mm_rsp.product;
               if (more_bits) begin
                  mm_req.start        = 1'b1;
                  mm_req.multiplicand = base_ff;
                  mm_req.multiplier   = base_ff;
               end
            end
         end
         ST_SQUARE: begin
            if (mm_rsp.done) begin
               base_in = mm_rsp.product;
               exp_in  = {1'b0, exp_ff[OPERAND_BITS-1:1]};
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         modulus_ff <= operand_type'(1);
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            modulus_ff <= csr_modulus;
         end
      end
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      result_ff <= result_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_power_result = result_ff;

endmodule
